### rtl/tsdp_pkg.sv
// tsdp_pkg: shared constants and types for the tick scheduler with debounced pause
// no dependencies; used by tsdp_cfg_if and the top level
`timescale 1ns / 1ps

package tsdp_pkg;

  // width of the blink and sample counters
  localparam int unsigned CNT_W = 16;
  // width of one configuration register
  localparam int unsigned REG_W = 16;
  // compare width covering both counter and register
  localparam int unsigned CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = REG_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_B  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE   = 2'd2;

  // register reset values
  localparam logic [REG_W-1:0] BLINK_A_RST = 16'd1000;
  localparam logic [REG_W-1:0] BLINK_B_RST = 16'd1300;
  localparam logic [REG_W-1:0] SAMPLE_RST  = 16'd50;

  // debounce states
  typedef enum logic [1:0] {
    DB_DOWN    = 2'd0,
    DB_RISING  = 2'd1,
    DB_UP      = 2'd2,
    DB_FALLING = 2'd3
  } db_state_e;

endpackage

### rtl/tsdp_cfg_if.sv
// tsdp_cfg_if: configuration write channel (register index and write data)
// depends on tsdp_pkg for widths
`timescale 1ns / 1ps

interface tsdp_cfg_if;
  import tsdp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tsdp_in_if.sv
// tsdp_in_if: tick channel, one item per timer tick with the button level
// no package dependencies
`timescale 1ns / 1ps

interface tsdp_in_if;
  logic valid;
  logic ready;
  logic button_pressed;

  modport source (output valid, output button_pressed, input ready);
  modport sink   (input valid, input button_pressed, output ready);
endinterface

### rtl/tsdp_out_if.sv
// tsdp_out_if: result channel, LED levels, pause flag and debounce status per tick
// no package dependencies
`timescale 1ns / 1ps

interface tsdp_out_if;
  logic       valid;
  logic       ready;
  logic       led_a;
  logic       led_b;
  logic       paused_out;
  logic [1:0] debounce_phase;
  logic       sampled;

  modport source (
    output valid, output led_a, output led_b, output paused_out,
    output debounce_phase, output sampled, input ready
  );
  modport sink (
    input valid, input led_a, input led_b, input paused_out,
    input debounce_phase, input sampled, output ready
  );
endinterface

### rtl/tick_scheduler_with_debounced_pause.sv
// tick_scheduler_with_debounced_pause: top level, blink counters, sample counter, debouncer
// depends on tsdp_pkg, tsdp_cfg_if, tsdp_in_if, tsdp_out_if
`timescale 1ns / 1ps

// Usage
//   tick_i   : one item per timer tick, carrying button_pressed (1 = pressed).
//   result_o : one item per tick with both LED levels, the pause flag, the
//              debounce phase and whether the button was sampled this tick,
//              all taken after the tick's update.
//   cfg_i    : register writes, index 0 blink A interval, 1 blink B interval,
//              2 sample interval; other indexes are ignored. Always ready;
//              write only while no tick is in flight.
// Timing
//   Result valid rises in the cycle after tick acceptance. Throughput is one
//   tick per cycle while no result stalls: all counter and debounce state is
//   updated in the accept cycle; the result is held in one output register.
// Reset
//   Counters and LEDs clear, the pause flag clears, the debouncer starts in
//   the up state and the intervals return to 1000, 1300 and 50.
// Backpressure
//   While a result waits and result_o.ready is low, tick_i.ready is low; a
//   new tick is taken in the same cycle the waiting result is taken.
module tick_scheduler_with_debounced_pause (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsdp_cfg_if.sink    cfg_i,
  tsdp_in_if.sink     tick_i,
  tsdp_out_if.source  result_o
);
  import tsdp_pkg::*;

  // configuration registers
  logic [REG_W-1:0] blink_a_q, blink_b_q, sample_q;

  // tick state
  logic [CNT_W-1:0] count_a_q, count_a_d;
  logic [CNT_W-1:0] count_b_q, count_b_d;
  logic [CNT_W-1:0] count_s_q, count_s_d;
  logic             paused_q, paused_d;
  db_state_e        db_q, db_d;
  logic             led_a_q, led_a_d;
  logic             led_b_q, led_b_d;

  // result register
  logic       out_valid_q;
  logic       res_led_a_q, res_led_b_q, res_paused_q, res_sampled_q;
  logic [1:0] res_phase_q;

  logic             tick_acc;
  logic [CNT_W-1:0] inc_a, inc_b, inc_s;
  logic             hit_a, hit_b, hit_s;
  logic             toggle_a, toggle_b;

  // handshake
  assign cfg_i.ready  = 1'b1;
  assign tick_i.ready = !out_valid_q || result_o.ready;
  assign tick_acc     = tick_i.valid && tick_i.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_a_q <= BLINK_A_RST;
      blink_b_q <= BLINK_B_RST;
      sample_q  <= SAMPLE_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_BLINK_A) blink_a_q <= cfg_i.data;
      if (cfg_i.index == REG_BLINK_B) blink_b_q <= cfg_i.data;
      if (cfg_i.index == REG_SAMPLE)  sample_q  <= cfg_i.data;
    end
  end

  // counter increments and interval compares
  assign inc_a = count_a_q + CNT_W'(1);
  assign inc_b = count_b_q + CNT_W'(1);
  assign inc_s = count_s_q + CNT_W'(1);
  assign hit_a = CMP_W'(inc_a) >= CMP_W'(blink_a_q);
  assign hit_b = CMP_W'(inc_b) >= CMP_W'(blink_b_q);
  assign hit_s = CMP_W'(inc_s) >= CMP_W'(sample_q);

  // blink counters advance only while not paused
  assign toggle_a  = !paused_q && hit_a;
  assign toggle_b  = !paused_q && hit_b;
  assign count_a_d = paused_q ? count_a_q : (hit_a ? '0 : inc_a);
  assign count_b_d = paused_q ? count_b_q : (hit_b ? '0 : inc_b);
  assign count_s_d = hit_s ? '0 : inc_s;
  assign led_a_d   = led_a_q ^ toggle_a;
  assign led_b_d   = led_b_q ^ toggle_b;

  // debounce next state and pause flag, only on a sample tick
  always_comb begin
    db_d     = db_q;
    paused_d = paused_q;
    if (hit_s) begin
      unique case (db_q)
        DB_DOWN: begin
          if (!tick_i.button_pressed) db_d = DB_RISING;
        end
        DB_RISING: begin
          if (tick_i.button_pressed) begin
            db_d = DB_DOWN;
          end else begin
            db_d     = DB_UP;
            paused_d = 1'b0;
          end
        end
        DB_UP: begin
          if (tick_i.button_pressed) db_d = DB_FALLING;
        end
        DB_FALLING: begin
          if (tick_i.button_pressed) begin
            db_d     = DB_DOWN;
            paused_d = 1'b1;
          end else begin
            db_d = DB_UP;
          end
        end
        default: begin
          db_d = DB_UP;
        end
      endcase
    end
  end

  // tick state update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
      count_s_q <= '0;
      paused_q  <= 1'b0;
      db_q      <= DB_UP;
      led_a_q   <= 1'b0;
      led_b_q   <= 1'b0;
    end else if (tick_acc) begin
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      count_s_q <= count_s_d;
      paused_q  <= paused_d;
      db_q      <= db_d;
      led_a_q   <= led_a_d;
      led_b_q   <= led_b_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_acc) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      res_led_a_q   <= led_a_d;
      res_led_b_q   <= led_b_d;
      res_paused_q  <= paused_d;
      res_phase_q   <= db_d;
      res_sampled_q <= hit_s;
    end
  end

  // result outputs
  always_comb begin
    result_o.valid          = out_valid_q;
    result_o.led_a          = res_led_a_q;
    result_o.led_b          = res_led_b_q;
    result_o.paused_out     = res_paused_q;
    result_o.debounce_phase = res_phase_q;
    result_o.sampled        = res_sampled_q;
  end

  // a taken tick always leaves a result behind
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> out_valid_q)
    else $error("accepted tick produced no result");

  // a waiting result blocks new ticks
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !tick_i.ready)
    else $error("tick accepted over a stalled result");

  // pause is set only by a confirmed press from the falling state
  a_pause_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(paused_q) |-> ($past(db_q == DB_FALLING) && db_q == DB_DOWN))
    else $error("pause set outside a confirmed press");

  // pause is cleared only by a confirmed release from the rising state
  a_pause_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(paused_q) |-> ($past(db_q == DB_RISING) && db_q == DB_UP))
    else $error("pause cleared outside a confirmed release");

  // blink counters and LEDs freeze while paused
  a_paused_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && paused_q) |=>
      ($stable(count_a_q) && $stable(count_b_q) && $stable(led_a_q) && $stable(led_b_q)))
    else $error("blink state moved while paused");

endmodule
